[rtl/lgrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types and constants of the Laplace grid relaxation solver
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int GridDflt        = 128;
  localparam int MaxSpacingDflt  = 4;
  localparam int ValueBitsDflt   = 24;
  localparam int FuncBits        = 63;
  localparam logic [FuncBits-1:0] FuncMax = {FuncBits{1'b1}};

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_RELAX  = 2'd2,
    ACT_INTERP = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_TOL   = 1'd0,
    CFG_SWEEP = 1'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ_RQ,
    ST_READ_WT,
    ST_READ_DONE,
    ST_RLX_RD,
    ST_RLX_WT,
    ST_RLX_CALC,
    ST_RLX_WR,
    ST_EN_RD,
    ST_EN_WT,
    ST_EN_SQX,
    ST_EN_SQY,
    ST_EN_SQ2,
    ST_EN_ACC,
    ST_EN_FIN,
    ST_CONV_MUL,
    ST_CONV_CMP,
    ST_IP_RD,
    ST_IP_WT,
    ST_IP_WR,
    ST_DONE
  } state_e;

endpackage : lgrs_pkg
`default_nettype wire

[rtl/lgrs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_ram: single-port RAM with registered read
// ----------------------------------------------------------------------------
module lgrs_ram #(
  parameter int Width = 24,
  parameter int Depth = 16641
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule : lgrs_ram
`default_nettype wire

[rtl/laplace_grid_relaxation_solver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// laplace_grid_relaxation_solver: multigrid Gauss-Seidel on a square grid
// ----------------------------------------------------------------------------
// After reset the block clears the (GRID+1)^2 cell memory one cell a cycle
// and holds busy high meanwhile. All grid traffic runs through one
// single-port RAM, one access per cycle, and the squares of the energy and
// the tolerance product share one 32x32 multiplier under a sequencer. A
// relax sweep updates each interior point, then sums the energy over each
// cell and runs the tolerance test; an interpolate item fills each coarse
// cell. Each item gives one result beat on done_o in the first cycle busy
// is low again; the receiver cannot stall it.
module laplace_grid_relaxation_solver
  import lgrs_pkg::*;
#(
  parameter int Grid           = GridDflt,
  parameter int MaxSpacingLog2 = MaxSpacingDflt,
  parameter int ValueBits      = ValueBitsDflt
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic [1:0]            action_i,
  input  wire logic [7:0]            row_i,
  input  wire logic [7:0]            col_i,
  input  wire logic signed [ValueBits-1:0] value_i,
  input  wire logic [2:0]            spacing_log2_i,
  output logic                       done_o,
  output logic signed [ValueBits-1:0] read_value_o,
  output logic [15:0]                sweeps_o,
  output logic [FuncBits-1:0]        functional_o,
  output logic                       converged_o
);
  localparam int Side   = Grid + 1;
  localparam int Depth  = Side * Side;
  localparam int AW     = $clog2(Depth);
  localparam int CwGrid = $clog2(Side + 1) + 1;
  localparam int CwSpan = (MaxSpacingLog2 + 3 > 9) ? MaxSpacingLog2 + 3 : 9;
  localparam int CW     = (CwGrid > CwSpan) ? CwGrid : CwSpan;
  localparam int DW     = ValueBits + 3;
  localparam int SW     = 2 * DW;

  state_e            st_q, st_d;
  logic [31:0]       tol_q;
  logic [15:0]       maxsw_q;
  logic [AW-1:0]     clr_q;
  logic [CW-1:0]     i_q, j_q, i_d, j_d;
  logic [CW-1:0]     k_q, k_d;
  logic [2:0]        ph_q, ph_d;
  logic signed [ValueBits-1:0] a_q, b_q, c_q, d_q;
  logic signed [ValueBits-1:0] wv_q;
  logic [AW-1:0]     wa_q;
  logic [1:0]        act_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [SW:0]       sq_q;
  logic [63:0]       q_q, rem_q, s_q, prev_q;
  logic [15:0]       cnt_q;
  logic              conv_q;
  logic [95:0]       prod_q;
  logic [1:0]        mph_q;

  logic              we;
  logic [AW-1:0]     addr;
  logic [ValueBits-1:0] wdata, rdata;

  lgrs_ram #(.Width(ValueBits), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] cidx(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [AW+CW:0] t;
    t = (AW+CW+1)'(r) * (AW+CW+1)'(Side) + (AW+CW+1)'(c);
    return t[AW-1:0];
  endfunction

  logic [2:0] sp;
  assign sp = (int'(spacing_log2_i) > MaxSpacingLog2) ? 3'(MaxSpacingLog2) : spacing_log2_i;

  logic [CW-1:0] h;
  assign h = k_q >> 1;

  // neighbor/corner sums
  logic signed [ValueBits+1:0] sum4, sab, sbd, scd, sac;
  assign sum4 = (ValueBits+2)'(a_q) + (ValueBits+2)'(b_q) + (ValueBits+2)'(c_q)
              + (ValueBits+2)'(d_q);
  assign sab  = (ValueBits+2)'(a_q) + (ValueBits+2)'(b_q);
  assign sbd  = (ValueBits+2)'(b_q) + (ValueBits+2)'(d_q);
  assign scd  = (ValueBits+2)'(c_q) + (ValueBits+2)'(d_q);
  assign sac  = (ValueBits+2)'(a_q) + (ValueBits+2)'(c_q);

  logic signed [DW-1:0] dxc, dyc;
  assign dxc = DW'(b_q) - DW'(a_q) + DW'(d_q) - DW'(c_q);
  assign dyc = DW'(c_q) - DW'(a_q) + DW'(d_q) - DW'(b_q);

  logic [DW-1:0] mx, my;
  assign mx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign my = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

  logic [63:0] part, qsum, dabs;
  assign part = {1'b0, 63'(sq_q >> 3)};
  assign qsum = q_q + part;
  assign dabs = (s_q > prev_q) ? s_q - prev_q : prev_q - s_q;

  // shared 32x32 multiplier: squares of the energy, then tol*prev in two halves
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    case (st_q)
      ST_EN_SQY: begin mul_a = 32'(mx); mul_b = 32'(mx); end
      ST_EN_SQ2: begin mul_a = 32'(my); mul_b = 32'(my); end
      default: begin
        mul_a = tol_q;
        mul_b = mph_q[0] ? prev_q[63:32] : prev_q[31:0];
      end
    endcase
  end

  logic last_i, last_j;

  always_comb begin
    st_d = st_q; i_d = i_q; j_d = j_q; k_d = k_q; ph_d = ph_q;
    we = 1'b0; addr = cidx(i_q, j_q); wdata = wv_q;
    last_i = 1'b0; last_j = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        we = 1'b1; addr = clr_q; wdata = '0;
        if (clr_q == AW'(Depth - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          k_d = CW'(1) << sp;
          case (action_e'(action_i))
            ACT_WRITE: begin
              i_d = CW'(row_i); j_d = CW'(col_i); st_d = ST_WRITE;
            end
            ACT_READ: begin
              i_d = CW'(row_i); j_d = CW'(col_i); st_d = ST_READ_RQ;
            end
            ACT_RELAX: begin
              ph_d = '0;
              if ((CW'(2) << sp) <= CW'(Grid)) begin
                i_d = CW'(1) << sp; j_d = CW'(1) << sp; st_d = ST_RLX_RD;
              end else if ((CW'(1) << sp) <= CW'(Grid)) begin
                i_d = '0; j_d = '0; st_d = ST_EN_RD;
              end else begin
                st_d = ST_EN_FIN;
              end
            end
            default: begin
              i_d = '0; j_d = '0; ph_d = '0;
              st_d = (sp == 3'd0 || (CW'(1) << sp) > CW'(Grid)) ? ST_DONE : ST_IP_RD;
            end
          endcase
        end
      end
      ST_WRITE: begin
        we = (i_q <= CW'(Grid)) && (j_q <= CW'(Grid));
        addr = wa_q;
        st_d = ST_DONE;
      end
      ST_READ_RQ: begin addr = wa_q; st_d = ST_READ_WT; end
      ST_READ_WT: st_d = ST_READ_DONE;
      ST_READ_DONE: st_d = ST_DONE;
      ST_RLX_RD: begin
        case (ph_q)
          3'd0: addr = cidx(i_q + k_q, j_q);
          3'd1: addr = cidx(i_q - k_q, j_q);
          3'd2: addr = cidx(i_q, j_q + k_q);
          default: addr = cidx(i_q, j_q - k_q);
        endcase
        st_d = ST_RLX_WT;
      end
      ST_RLX_WT: begin
        ph_d = ph_q + 3'd1;
        st_d = (ph_q == 3'd3) ? ST_RLX_CALC : ST_RLX_RD;
      end
      ST_RLX_CALC: st_d = ST_RLX_WR;
      ST_RLX_WR: begin
        we = 1'b1; ph_d = '0;
        last_j = (j_q + (k_q << 1)) > CW'(Grid);
        last_i = (i_q + (k_q << 1)) > CW'(Grid);
        if (!last_j) begin
          j_d = j_q + k_q; st_d = ST_RLX_RD;
        end else if (!last_i) begin
          j_d = k_q; i_d = i_q + k_q; st_d = ST_RLX_RD;
        end else begin
          i_d = '0; j_d = '0; st_d = ST_EN_RD;
        end
      end
      ST_EN_RD: begin
        case (ph_q)
          3'd0: addr = cidx(i_q, j_q);
          3'd1: addr = cidx(i_q + k_q, j_q);
          3'd2: addr = cidx(i_q, j_q + k_q);
          default: addr = cidx(i_q + k_q, j_q + k_q);
        endcase
        st_d = ST_EN_WT;
      end
      ST_EN_WT: begin
        ph_d = ph_q + 3'd1;
        st_d = (ph_q == 3'd3) ? ST_EN_SQX : ST_EN_RD;
      end
      ST_EN_SQX: st_d = ST_EN_SQY;
      ST_EN_SQY: st_d = ST_EN_SQ2;
      ST_EN_SQ2: st_d = ST_EN_ACC;
      ST_EN_ACC: begin
        ph_d = '0;
        last_j = (j_q + (k_q << 1)) > CW'(Grid);
        last_i = (i_q + (k_q << 1)) > CW'(Grid);
        if (!last_j) begin
          j_d = j_q + k_q; st_d = ST_EN_RD;
        end else if (!last_i) begin
          j_d = '0; i_d = i_q + k_q; st_d = ST_EN_RD;
        end else begin
          st_d = ST_EN_FIN;
        end
      end
      ST_EN_FIN: st_d = ST_CONV_MUL;
      ST_CONV_MUL: if (mph_q == 2'd2) st_d = ST_CONV_CMP;
      ST_CONV_CMP: begin
        if (conv_q || cnt_q >= ((maxsw_q == 16'd0) ? 16'd1 : maxsw_q)) begin
          st_d = ST_DONE;
        end else begin
          ph_d = '0;
          if ((k_q << 1) <= CW'(Grid)) begin
            i_d = k_q; j_d = k_q; st_d = ST_RLX_RD;
          end else if (k_q <= CW'(Grid)) begin
            i_d = '0; j_d = '0; st_d = ST_EN_RD;
          end else begin
            st_d = ST_EN_FIN;
          end
        end
      end
      ST_IP_RD: begin
        case (ph_q)
          3'd0: addr = cidx(i_q, j_q);
          3'd1: addr = cidx(i_q + k_q, j_q);
          3'd2: addr = cidx(i_q, j_q + k_q);
          default: addr = cidx(i_q + k_q, j_q + k_q);
        endcase
        st_d = ST_IP_WT;
      end
      ST_IP_WT: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd3) begin ph_d = '0; st_d = ST_IP_WR; end
        else st_d = ST_IP_RD;
      end
      ST_IP_WR: begin
        we = 1'b1;
        case (ph_q)
          3'd0: begin addr = cidx(i_q + h, j_q + h); wdata = ValueBits'(sum4 >>> 2); end
          3'd1: begin addr = cidx(i_q + k_q, j_q + h); wdata = ValueBits'(sbd >>> 1); end
          3'd2: begin addr = cidx(i_q + h, j_q + k_q); wdata = ValueBits'(scd >>> 1); end
          3'd3: begin addr = cidx(i_q + h, j_q); wdata = ValueBits'(sab >>> 1); end
          default: begin addr = cidx(i_q, j_q + h); wdata = ValueBits'(sac >>> 1); end
        endcase
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd4) begin
          ph_d = '0;
          last_j = (j_q + (k_q << 1)) > CW'(Grid);
          last_i = (i_q + (k_q << 1)) > CW'(Grid);
          if (!last_j) begin
            j_d = j_q + k_q; st_d = ST_IP_RD;
          end else if (!last_i) begin
            j_d = '0; i_d = i_q + k_q; st_d = ST_IP_RD;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0;
      tol_q <= 32'd43; maxsw_q <= 16'hFFFF;
      prev_q <= '0; cnt_q <= '0;
      done_o <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= '0; mph_q <= '0;
      conv_q <= 1'b0;
    end else begin
      st_q <= st_d; i_q <= i_d; j_q <= j_d; k_q <= k_d; ph_q <= ph_d;
      done_o <= (st_q == ST_DONE);
      if (st_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TOL:   tol_q   <= cfg_data_i;
          default:   maxsw_q <= cfg_data_i[15:0];
        endcase
      end
      if (st_q == ST_IDLE && start && action_e'(action_i) == ACT_RELAX) begin
        cnt_q <= '0; conv_q <= 1'b0;
      end
      if (st_q == ST_EN_FIN) mph_q <= '0;
      if (st_q == ST_CONV_MUL) mph_q <= mph_q + 2'd1;
      if (st_q == ST_CONV_CMP) begin
        prev_q <= s_q;
      end
      if (st_q == ST_EN_FIN) cnt_q <= cnt_q + 16'd1;
      if (st_q == ST_CONV_MUL && mph_q == 2'd2) begin
        // dabs*2^32 <= tol*prev, both as 96-bit
        conv_q <= (cnt_q >= 16'd2) && ({dabs, 32'd0} <= {32'd0, prod_q[63:0]}
                  + {prod_q[95:64], 64'd0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) begin
      act_q <= action_i;
      wv_q  <= value_i;
      wa_q  <= cidx(CW'(row_i), CW'(col_i));
      a_q <= '0;
      q_q <= '0; rem_q <= '0; s_q <= '0;
      read_value_o <= '0; sweeps_o <= '0; functional_o <= '0; converged_o <= 1'b0;
    end
    if (st_q == ST_READ_DONE) begin
      read_value_o <= (i_q <= CW'(Grid) && j_q <= CW'(Grid)) ? rdata : '0;
    end
    if (st_q == ST_RLX_WT || st_q == ST_EN_WT || st_q == ST_IP_WT) begin
      case (ph_q)
        3'd0: a_q <= rdata;
        3'd1: b_q <= rdata;
        3'd2: c_q <= rdata;
        default: d_q <= rdata;
      endcase
    end
    if (st_q == ST_RLX_CALC) wv_q <= ValueBits'(sum4 >>> 2);
    if ((st_q == ST_RLX_WR && last_i && last_j) || st_q == ST_CONV_CMP) begin
      q_q <= '0; rem_q <= '0;
    end
    if (st_q == ST_EN_SQX) begin
      dx_q <= dxc; dy_q <= dyc;
    end
    if (st_q == ST_EN_SQY) sq_q <= (SW+1)'(mul_p);
    if (st_q == ST_EN_SQ2) sq_q <= sq_q + (SW+1)'(mul_p);
    if (st_q == ST_EN_ACC) begin
      rem_q <= rem_q + 64'(sq_q[2:0]);
      q_q   <= (qsum > {1'b0, FuncMax}) ? {1'b0, FuncMax} : qsum;
    end
    if (st_q == ST_EN_FIN) begin
      s_q <= ((q_q + (rem_q >> 3)) > {1'b0, FuncMax}) ? {1'b0, FuncMax}
             : q_q + (rem_q >> 3);
    end
    if (st_q == ST_CONV_MUL) begin
      case (mph_q)
        2'd0: prod_q <= 96'(mul_p);
        2'd1: prod_q <= prod_q + {mul_p, 32'd0};
        default: prod_q <= prod_q;
      endcase
    end
    if (st_q == ST_CONV_CMP) begin
      sweeps_o <= cnt_q; functional_o <= s_q[FuncBits-1:0]; converged_o <= conv_q;
    end
    if (st_q == ST_DONE && act_q != 2'(ACT_RELAX)) begin
      sweeps_o <= '0; functional_o <= '0; converged_o <= 1'b0;
      if (act_q != 2'(ACT_READ)) read_value_o <= '0;
    end
  end

  assign busy = (st_q != ST_IDLE);
endmodule : laplace_grid_relaxation_solver
`default_nettype wire
